FILE: rtl/linear_recurrence_mod_power_defines.svh
// Assertion macros used by the checker file.
// The enclosing module must provide signals named clk and rst.
`ifndef LINEAR_RECURRENCE_MOD_POWER_DEFINES_SVH
`define LINEAR_RECURRENCE_MOD_POWER_DEFINES_SVH

// Same-cycle implication.
`define LRMP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LRMP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lrmp_pkg.sv
package lrmp_pkg;

  localparam int RES_W          = 16;
  localparam int IN_W           = 16;
  localparam int OUT_W          = 14;
  localparam int PROD_W         = 32;
  localparam int OP_W           = 3;
  localparam int DEF_MODULUS    = 10000;
  localparam int DEF_INDEX_BITS = 32;

  localparam logic [OP_W-1:0] OP_LAST_LOAD = 3'd3;
  localparam logic [OP_W-1:0] OP_LAST_MAT  = 3'd7;
  localparam logic [OP_W-1:0] OP_LAST_FIN  = 3'd1;

  typedef logic [RES_W-1:0] res_t;
  typedef res_t [3:0] mat_t;

  typedef enum logic [1:0] {
    MODE_LOAD,
    MODE_AB,
    MODE_BB,
    MODE_FIN
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LOAD_WAIT,
    ST_BIT,
    ST_MUL_AB,
    ST_WAIT_AB,
    ST_STEP,
    ST_MUL_BB,
    ST_WAIT_BB,
    ST_FIN,
    ST_WAIT_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    mode_t           mode;
    logic [OP_W-1:0] op;
  } tag_t;

  typedef struct packed {
    logic            capture;
    logic            issue;
    mode_t           mode;
    logic [OP_W-1:0] op;
    logic            shift;
    logic            take_small;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic e_lsb;
    logic e_last;
    logic k_small;
  } status_t;

endpackage

FILE: rtl/lrmp_modmul.sv
module lrmp_modmul
  import lrmp_pkg::*;
#(
  parameter int MODULUS = DEF_MODULUS
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  tag_t in_tag,
  input  res_t in_a,
  input  res_t in_b,
  output logic out_valid,
  output tag_t out_tag,
  output res_t out_res,
  output logic busy
);

  // Reciprocal for the quotient estimate; the estimate is low by at most one.
  localparam logic [63:0]       MU_WIDE = 64'h1_0000_0000 / 64'(MODULUS);
  localparam logic [PROD_W-1:0] MU      = MU_WIDE[PROD_W-1:0];
  localparam logic [PROD_W-1:0] MOD_P   = PROD_W'(MODULUS);
  localparam logic [RES_W:0]    MOD_X   = (RES_W+1)'(MODULUS);

  logic              v1, v2, v3, v4;
  tag_t              t1, t2, t3, t4;
  logic [PROD_W-1:0] x1, x2, x3;
  logic [PROD_W-1:0] q2, qm3;
  res_t              r4;

  logic [2*PROD_W-1:0] mu_prod;
  logic [PROD_W-1:0]   diff;
  logic [RES_W:0]      rem;

  assign mu_prod = {{PROD_W{1'b0}}, x1} * {{PROD_W{1'b0}}, MU};
  assign diff    = x3 - qm3;
  assign rem     = diff[RES_W:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    t1  <= in_tag;
    x1  <= PROD_W'(in_a) * PROD_W'(in_b);
    t2  <= t1;
    x2  <= x1;
    q2  <= mu_prod[2*PROD_W-1:PROD_W];
    t3  <= t2;
    x3  <= x2;
    qm3 <= q2 * MOD_P;
    t4  <= t3;
    r4  <= (rem >= MOD_X) ? RES_W'(rem - MOD_X) : rem[RES_W-1:0];
  end

  assign out_valid = v4;
  assign out_tag   = t4;
  assign out_res   = r4;
  assign busy      = v1 | v2 | v3 | v4;

endmodule

FILE: rtl/lrmp_datapath.sv
module lrmp_datapath
  import lrmp_pkg::*;
#(
  parameter int MODULUS    = DEF_MODULUS,
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [IN_W-1:0]       first_term,
  input  logic [IN_W-1:0]       second_term,
  input  logic [IN_W-1:0]       coef_prev,
  input  logic [IN_W-1:0]       coef_prev2,
  input  logic [INDEX_BITS-1:0] term_index,
  output logic [OUT_W-1:0]      term_value
);

  localparam res_t           ONE_MOD = RES_W'(1 % MODULUS);
  localparam logic [RES_W:0] MOD_X   = (RES_W+1)'(MODULUS);

  res_t raw_a0, raw_a1, raw_p, raw_q;
  res_t a0, a1;
  mat_t acc, base;
  res_t [2:0] newm;
  res_t partial;
  res_t result;
  logic [INDEX_BITS-1:0] e;
  logic k_small, k_one;

  mat_t mat_a, mat_b, fin_b;
  res_t opa, opb;

  logic mm_valid, mm_busy;
  tag_t mm_tag;
  res_t mm_res;

  logic [RES_W:0] sum;
  res_t entry;

  assign fin_b = {{RES_W{1'b0}}, a0, {RES_W{1'b0}}, a1};

  always_comb begin
    mat_a = acc;
    mat_b = base;
    case (cmd.mode)
      MODE_AB: begin
        mat_a = acc;
        mat_b = base;
      end
      MODE_BB: begin
        mat_a = base;
        mat_b = base;
      end
      MODE_FIN: begin
        mat_a = acc;
        mat_b = fin_b;
      end
      default: begin
        mat_a = acc;
        mat_b = base;
      end
    endcase
  end

  // Op code {row, column, term}: term t of entry (row, column); in load mode it selects the raw input.
  always_comb begin
    opa = '0;
    opb = '0;
    if (cmd.mode == MODE_LOAD) begin
      opb = RES_W'(1);
      case (cmd.op)
        3'd0:    opa = raw_a0;
        3'd1:    opa = raw_a1;
        3'd2:    opa = raw_p;
        3'd3:    opa = raw_q;
        default: opa = '0;
      endcase
    end else begin
      case (cmd.op)
        3'd0: begin opa = mat_a[0]; opb = mat_b[0]; end
        3'd1: begin opa = mat_a[1]; opb = mat_b[2]; end
        3'd2: begin opa = mat_a[0]; opb = mat_b[1]; end
        3'd3: begin opa = mat_a[1]; opb = mat_b[3]; end
        3'd4: begin opa = mat_a[2]; opb = mat_b[0]; end
        3'd5: begin opa = mat_a[3]; opb = mat_b[2]; end
        3'd6: begin opa = mat_a[2]; opb = mat_b[1]; end
        3'd7: begin opa = mat_a[3]; opb = mat_b[3]; end
        default: begin opa = '0; opb = '0; end
      endcase
    end
  end

  lrmp_modmul #(
    .MODULUS(MODULUS)
  ) u_modmul (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.issue),
    .in_tag   ({cmd.mode, cmd.op}),
    .in_a     (opa),
    .in_b     (opb),
    .out_valid(mm_valid),
    .out_tag  (mm_tag),
    .out_res  (mm_res),
    .busy     (mm_busy)
  );

  assign sum   = {1'b0, partial} + {1'b0, mm_res};
  assign entry = (sum >= MOD_X) ? RES_W'(sum - MOD_X) : sum[RES_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_a0  <= first_term;
      raw_a1  <= second_term;
      raw_p   <= coef_prev;
      raw_q   <= coef_prev2;
      acc     <= {ONE_MOD, {RES_W{1'b0}}, {RES_W{1'b0}}, ONE_MOD};
      base[2] <= ONE_MOD;
      base[3] <= '0;
      e       <= term_index - INDEX_BITS'(1);
      k_small <= (term_index[INDEX_BITS-1:1] == '0);
      k_one   <= term_index[0];
    end
    if (cmd.shift) begin
      e <= e >> 1;
    end
    if (cmd.take_small) begin
      result <= k_one ? a1 : a0;
    end
    if (mm_valid) begin
      if (mm_tag.mode == MODE_LOAD) begin
        case (mm_tag.op)
          3'd0:    a0      <= mm_res;
          3'd1:    a1      <= mm_res;
          3'd2:    base[0] <= mm_res;
          3'd3:    base[1] <= mm_res;
          default: ;
        endcase
      end else if (!mm_tag.op[0]) begin
        partial <= mm_res;
      end else if (mm_tag.mode == MODE_FIN) begin
        result <= entry;
      end else if (mm_tag.op[2:1] != 2'd3) begin
        newm[mm_tag.op[2:1]] <= entry;
      end else if (mm_tag.mode == MODE_AB) begin
        // All operand reads are issued before the last entry returns.
        acc <= {entry, newm[2], newm[1], newm[0]};
      end else begin
        base <= {entry, newm[2], newm[1], newm[0]};
      end
    end
  end

  assign status.pipe_busy = mm_busy;
  assign status.e_lsb     = e[0];
  assign status.e_last    = (e[INDEX_BITS-1:1] == '0);
  assign status.k_small   = k_small;

  assign term_value = result[OUT_W-1:0];

endmodule

FILE: rtl/lrmp_ctrl.sv
module lrmp_ctrl
  import lrmp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  state_t          state, state_next;
  logic [OP_W-1:0] op_cnt, op_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      op_cnt <= '0;
    end else begin
      state  <= state_next;
      op_cnt <= op_cnt_next;
    end
  end

  always_comb begin
    state_next  = state;
    op_cnt_next = op_cnt;
    cmd         = '0;
    cmd.mode    = MODE_LOAD;
    cmd.op      = op_cnt;
    done        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          op_cnt_next = '0;
          state_next  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.issue = 1'b1;
        cmd.mode  = MODE_LOAD;
        if (op_cnt == OP_LAST_LOAD) begin
          op_cnt_next = '0;
          state_next  = ST_LOAD_WAIT;
        end else begin
          op_cnt_next = op_cnt + 1'b1;
        end
      end
      ST_LOAD_WAIT: begin
        if (!status.pipe_busy) begin
          if (status.k_small) begin
            cmd.take_small = 1'b1;
            state_next     = ST_DONE;
          end else begin
            state_next = ST_BIT;
          end
        end
      end
      ST_BIT: begin
        state_next = status.e_lsb ? ST_MUL_AB : ST_STEP;
      end
      ST_MUL_AB: begin
        cmd.issue = 1'b1;
        cmd.mode  = MODE_AB;
        if (op_cnt == OP_LAST_MAT) begin
          op_cnt_next = '0;
          state_next  = ST_WAIT_AB;
        end else begin
          op_cnt_next = op_cnt + 1'b1;
        end
      end
      ST_WAIT_AB: begin
        if (!status.pipe_busy) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.shift  = 1'b1;
        state_next = status.e_last ? ST_FIN : ST_MUL_BB;
      end
      ST_MUL_BB: begin
        cmd.issue = 1'b1;
        cmd.mode  = MODE_BB;
        if (op_cnt == OP_LAST_MAT) begin
          op_cnt_next = '0;
          state_next  = ST_WAIT_BB;
        end else begin
          op_cnt_next = op_cnt + 1'b1;
        end
      end
      ST_WAIT_BB: begin
        if (!status.pipe_busy) begin
          state_next = ST_BIT;
        end
      end
      ST_FIN: begin
        cmd.issue = 1'b1;
        cmd.mode  = MODE_FIN;
        if (op_cnt == OP_LAST_FIN) begin
          op_cnt_next = '0;
          state_next  = ST_WAIT_FIN;
        end else begin
          op_cnt_next = op_cnt + 1'b1;
        end
      end
      ST_WAIT_FIN: begin
        if (!status.pipe_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

FILE: rtl/linear_recurrence_mod_power.sv
// Channel   Handshake           Payload
// --------  ------------------  ------------------------------------------------
// input     start, busy         first_term, second_term, coef_prev, coef_prev2,
//                               term_index
// result    done (one cycle)    term_value
//
// A transfer in is taken when start is high and busy is low; busy stays high until
// the cycle after done, which marks term_value for one cycle (no stall possible).
// Loading first reduces the four raw inputs in the multiplier; each bit of k-1 then takes
// a test state, a shift state and up to two 2x2 matrix products of 8 multiplier issues
// and a pipeline drain each. The final row product and done end the item; indices
// 0 and 1 go from loading straight to done. Synchronous reset idles the controller.
module linear_recurrence_mod_power
  import lrmp_pkg::*;
#(
  parameter int MODULUS    = DEF_MODULUS,
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [IN_W-1:0]       first_term,
  input  logic [IN_W-1:0]       second_term,
  input  logic [IN_W-1:0]       coef_prev,
  input  logic [IN_W-1:0]       coef_prev2,
  input  logic [INDEX_BITS-1:0] term_index,
  output logic                  done,
  output logic [OUT_W-1:0]      term_value
);

  cmd_t    cmd;
  status_t status;

  lrmp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  lrmp_datapath #(
    .MODULUS   (MODULUS),
    .INDEX_BITS(INDEX_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .first_term (first_term),
    .second_term(second_term),
    .coef_prev  (coef_prev),
    .coef_prev2 (coef_prev2),
    .term_index (term_index),
    .term_value (term_value)
  );

endmodule

FILE: rtl/lrmp_checker.sv
`include "linear_recurrence_mod_power_defines.svh"

module lrmp_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // A result only comes out of an item in progress.
  `LRMP_ASSERT_IMP(a_done_busy, done, busy, "done seen while idle")

  // An accepted transfer keeps the block busy in the next cycle.
  `LRMP_ASSERT_NXT(a_accept_busy, start && !busy, busy, "not busy after transfer in")

  // No item completes in the cycle right after it is taken.
  `LRMP_ASSERT_NXT(a_accept_nodone, start && !busy, !done, "result too early")

  // The block is free again right after a result.
  `LRMP_ASSERT_NXT(a_done_free, done, !busy && !done, "still busy after result")

endmodule

bind linear_recurrence_mod_power lrmp_checker u_lrmp_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done)
);

FILE: dv/linear_recurrence_mod_power_test.sv
`timescale 1ns / 100ps

module linear_recurrence_mod_power_test;
  import lrmp_pkg::*;

  localparam longint unsigned TERM_MOD = DEF_MODULUS;
  localparam int RANDOM_PER_PHASE = 530;
  localparam int DIRECTED_COUNT = 21;

  typedef struct packed {
    logic [IN_W-1:0]           a0;
    logic [IN_W-1:0]           a1;
    logic [IN_W-1:0]           p;
    logic [IN_W-1:0]           q;
    logic [DEF_INDEX_BITS-1:0] k;
    logic                      known;
    logic [OUT_W-1:0]          value;
  } term_case_t;

  // Rows with known set carry a value read straight off the recurrence;
  // the rest are checked against recurrence_term.
  localparam term_case_t DIRECTED_CASES [DIRECTED_COUNT] = '{
    '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0, 1'b1, 14'd0},
    '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 32'd0, 1'b1, 14'd5535},
    '{16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 32'd1, 1'b1, 14'd5535},
    '{16'd9999, 16'd1, 16'd1, 16'd1, 32'd0, 1'b1, 14'd9999},
    '{16'd7, 16'd10000, 16'd3, 16'd4, 32'd1, 1'b1, 14'd0},
    '{16'd3, 16'd5, 16'd2, 16'd7, 32'd2, 1'b1, 14'd31},
    '{16'd0, 16'd1, 16'd1, 16'd1, 32'd3, 1'b1, 14'd2},
    '{16'd0, 16'd1, 16'd1, 16'd1, 32'd10, 1'b1, 14'd55},
    '{16'd0, 16'd1, 16'd1, 16'd1, 32'd20, 1'b1, 14'd6765},
    '{16'd0, 16'd1, 16'd1, 16'd1, 32'd30, 1'b1, 14'd2040},
    '{16'd1234, 16'd5678, 16'd0, 16'd0, 32'd2, 1'b1, 14'd0},
    '{16'hFFFF, 16'hFFFF, 16'd10000, 16'd20000, 32'd5, 1'b1, 14'd0},
    '{16'd42, 16'd1234, 16'd1, 16'd0, 32'd1000, 1'b1, 14'd1234},
    '{16'd4321, 16'd8765, 16'd0, 16'd1, 32'd1000, 1'b1, 14'd4321},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd2, 1'b0, 14'd0},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 14'd0},
    '{16'd1, 16'd2, 16'hFFFF, 16'h0000, 32'h8000_0000, 1'b0, 14'd0},
    '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 32'h5555_5555, 1'b0, 14'd0},
    '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 32'hAAAA_AAAA, 1'b0, 14'd0},
    '{16'd9999, 16'd9999, 16'd9999, 16'd9999, 32'h0000_FFFF, 1'b0, 14'd0},
    '{16'd0, 16'd1, 16'd1, 16'd1, 32'hFFFF_FFFE, 1'b0, 14'd0}
  };

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic [IN_W-1:0]           first_term = '0;
  logic [IN_W-1:0]           second_term = '0;
  logic [IN_W-1:0]           coef_prev = '0;
  logic [IN_W-1:0]           coef_prev2 = '0;
  logic [DEF_INDEX_BITS-1:0] term_index = '0;
  logic                      done;
  logic [OUT_W-1:0]          term_value;

  logic [OUT_W-1:0] expected_terms [$];
  int               failure_count = 0;

  linear_recurrence_mod_power dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .first_term  (first_term),
    .second_term (second_term),
    .coef_prev   (coef_prev),
    .coef_prev2  (coef_prev2),
    .term_index  (term_index),
    .done        (done),
    .term_value  (term_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic res_t dot_mod(input res_t a, input res_t b, input res_t c, input res_t d);
    bit [63:0] sum;
    sum = 64'(a) * 64'(b) + 64'(c) * 64'(d);
    return res_t'(sum % TERM_MOD);
  endfunction

  function automatic mat_t mat_product(input mat_t x, input mat_t y);
    mat_t r;
    r[0] = dot_mod(x[0], y[0], x[1], y[2]);
    r[1] = dot_mod(x[0], y[1], x[1], y[3]);
    r[2] = dot_mod(x[2], y[0], x[3], y[2]);
    r[3] = dot_mod(x[2], y[1], x[3], y[3]);
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] recurrence_term(
    input logic [IN_W-1:0] a0_in, input logic [IN_W-1:0] a1_in,
    input logic [IN_W-1:0] p_in, input logic [IN_W-1:0] q_in,
    input logic [DEF_INDEX_BITS-1:0] k
  );
    res_t                      a0, a1, value;
    mat_t                      base, acc;
    logic [DEF_INDEX_BITS-1:0] e;
    a0 = res_t'(a0_in % TERM_MOD);
    a1 = res_t'(a1_in % TERM_MOD);
    if (k == 0) begin
      value = a0;
    end else if (k == 1) begin
      value = a1;
    end else begin
      base[0] = res_t'(p_in % TERM_MOD);
      base[1] = res_t'(q_in % TERM_MOD);
      base[2] = 1;
      base[3] = 0;
      acc[0] = 1;
      acc[1] = 0;
      acc[2] = 0;
      acc[3] = 1;
      // Square-and-multiply over the bits of k-1, least significant first.
      e = k - 1;
      while (e != 0) begin
        if (e[0]) acc = mat_product(acc, base);
        e = e >> 1;
        if (e != 0) base = mat_product(base, base);
      end
      value = dot_mod(acc[0], a1, acc[1], a0);
    end
    return value[OUT_W-1:0];
  endfunction

  function automatic logic [IN_W-1:0] random_operand();
    case ($urandom_range(9))
      0: return IN_W'($urandom_range(0, 4));
      1: begin
        case ($urandom_range(5))
          0: return 16'd9999;
          1: return 16'd10000;
          2: return 16'd10001;
          3: return 16'd19999;
          4: return 16'd20000;
          default: return 16'hFFFF;
        endcase
      end
      default: return IN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Most indices are short so that the run stays quick; 15 in 100 are full width.
  function automatic logic [DEF_INDEX_BITS-1:0] random_index();
    int sel;
    int w;
    sel = $urandom_range(99);
    w = $urandom_range(2, 12);
    if (sel < 10) return DEF_INDEX_BITS'($urandom_range(0, 1));
    if (sel < 20) return DEF_INDEX_BITS'($urandom_range(2, 4));
    if (sel < 30) return DEF_INDEX_BITS'($urandom);
    if (sel < 35) begin
      case ($urandom_range(2))
        0: return 32'hFFFF_FFFF;
        1: return 32'h8000_0000;
        default: return 32'h8000_0001;
      endcase
    end
    return DEF_INDEX_BITS'($urandom) & ((DEF_INDEX_BITS'(1) << w) - 1);
  endfunction

  // Holds start high until the block takes the transfer, then queues the
  // expected term. Start is left high so that a following item can go
  // straight out.
  task automatic transfer_item(
    input logic [IN_W-1:0] a0, input logic [IN_W-1:0] a1,
    input logic [IN_W-1:0] p, input logic [IN_W-1:0] q,
    input logic [DEF_INDEX_BITS-1:0] k,
    input logic known, input logic [OUT_W-1:0] known_value
  );
    first_term <= a0;
    second_term <= a1;
    coef_prev <= p;
    coef_prev2 <= q;
    term_index <= k;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_terms.push_back(known ? known_value : recurrence_term(a0, a1, p, q, k));
  endtask

  task automatic sender_gap(input int idle_pct);
    int gap;
    gap = ($urandom_range(3) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 6);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_terms.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_terms.size() == 0) begin
        $display("%0t: unexpected term_value, expected none, actual %0d", $time, term_value);
        failure_count++;
      end else if (term_value !== expected_terms[0]) begin
        $display("%0t: term_value mismatch, expected %0d, actual %0d",
                 $time, expected_terms[0], term_value);
        failure_count++;
        void'(expected_terms.pop_front());
      end else begin
        void'(expected_terms.pop_front());
      end
    end
  end

  initial begin
    int idle_pcts [3];
    idle_pcts = '{24, 63, 0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_CASES[i]) begin
      transfer_item(DIRECTED_CASES[i].a0, DIRECTED_CASES[i].a1, DIRECTED_CASES[i].p,
                    DIRECTED_CASES[i].q, DIRECTED_CASES[i].k,
                    DIRECTED_CASES[i].known, DIRECTED_CASES[i].value);
      sender_gap(idle_pcts[0]);
    end

    // The sender goes quiet at the end of every phase until all results are back.
    for (int phase = 0; phase < 3; phase++) begin
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        transfer_item(random_operand(), random_operand(), random_operand(),
                      random_operand(), random_index(), 1'b0, '0);
        sender_gap(idle_pcts[phase]);
      end
      drain_results();
    end

    repeat (1000) @(posedge clk);
    if (failure_count == 0 && expected_terms.size() == 0) begin
      $display("[linear_recurrence_mod_power] OK");
    end else begin
      $display("[linear_recurrence_mod_power] ERROR");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("[linear_recurrence_mod_power] ERROR");
    $finish;
  end

endmodule

FILE: linear_recurrence_mod_power.f
+incdir+rtl
rtl/lrmp_pkg.sv
rtl/lrmp_modmul.sv
rtl/lrmp_datapath.sv
rtl/lrmp_ctrl.sv
rtl/linear_recurrence_mod_power.sv
rtl/lrmp_checker.sv
dv/linear_recurrence_mod_power_test.sv
